// ----- rtl/gbfs_pkg.sv -----
// ----------------------------------------------------------------------------
// gbfs_pkg: shared constants and types for the grid BFS shortest path block
// Grid geometry, field widths, command and cell codes, sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbfs_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int CELL_W     = ROW_W + COL_W;
  localparam int CELL_COUNT = 1 << CELL_W;
  localparam int DIST_W     = 12;
  localparam int QENT_W     = CELL_W + DIST_W;
  localparam int SIZE_W     = 7;
  localparam int CFG_ADDR_W = 1;

  localparam int IN_ROW_W    = 6;
  localparam int IN_COL_W    = 6;
  localparam int KIND_W      = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 1 + KIND_W;
  localparam int OUT_TDATA_W = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [SIZE_W-1:0] ROWS_LIMIT = SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] COLS_LIMIT = SIZE_W'(MAX_COLS);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_OPEN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TARGET = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLS = 1'd1;

  typedef enum logic [7:0] {
    ST_CLR_ALL = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_CLR_VIS = 8'b0000_0100,
    ST_SEED    = 8'b0000_1000,
    ST_DEQ     = 8'b0001_0000,
    ST_HEAD    = 8'b0010_0000,
    ST_NB      = 8'b0100_0000,
    ST_FIN     = 8'b1000_0000
  } state_t;

endpackage

// ----- rtl/grid_bfs_shortest_path.sv -----
// ----------------------------------------------------------------------------
// grid_bfs_shortest_path: shortest 4-neighbor path in a grid maze
// Load items write one wall-map cell each. Run items: a visited-map clear sweep
// and a seed step, then for each dequeued cell a queue read, a head check and four
// neighbor probes through one shared neighbor unit and the wall/visited read ports.
// A finish step then hands out the result; the block takes no item during a run.
// After reset a sweep clears the wall and visited maps; no item is
// accepted during it, config writes are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_bfs_shortest_path
  import gbfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // cell_row[5:0], cell_col[11:6], zero pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // cmd[0], cell_kind[2:1]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // distance[11:0], zero pad
  output logic                   out_tuser,  // found[0]
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [SIZE_W-1:0]      cfg_wdata
);

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]   rows_r, cols_r;
  logic [ROW_W-1:0]    start_row_r, start_row_nxt, target_row_r, target_row_nxt;
  logic [COL_W-1:0]    start_col_r, start_col_nxt, target_col_r, target_col_nxt;
  logic                start_set_r, start_set_nxt, target_set_r, target_set_nxt;

  logic [CELL_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [CELL_W:0]     head_r, head_nxt, tail_r, tail_nxt;
  logic [CELL_W-1:0]   cur_idx_r, cur_idx_nxt;
  logic [DIST_W-1:0]   cur_dist_r, cur_dist_nxt;
  logic [2:0]          k_r, k_nxt;
  logic                pend_r, pend_nxt;
  logic [CELL_W-1:0]   pend_idx_r, pend_idx_nxt;

  logic                res_found_r, res_found_nxt;
  logic [DIST_W-1:0]   res_dist_r, res_dist_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [DIST_W-1:0]   out_dist_r, out_dist_nxt;

  logic                wall_mem [CELL_COUNT];
  logic                vis_mem  [CELL_COUNT];
  logic [QENT_W-1:0]   q_mem    [CELL_COUNT];

  logic                wall_we, wall_wdata, vis_we, vis_wdata, q_we;
  logic [CELL_W-1:0]   wall_waddr, vis_waddr, q_waddr, q_raddr;
  logic [QENT_W-1:0]   q_wdata, q_rdata;
  logic                wall_q, vis_q;

  logic                in_fire;
  logic                in_cmd;
  logic [KIND_W-1:0]   in_kind;
  logic [IN_ROW_W-1:0] in_row;
  logic [IN_COL_W-1:0] in_col;
  logic [CELL_W-1:0]   in_idx, start_idx;

  logic [ROW_W-1:0]    cur_row, nb_row;
  logic [COL_W-1:0]    cur_col, nb_col;
  logic                nb_ok;
  logic [CELL_W-1:0]   nb_idx;
  logic [DIST_W-1:0]   next_dist;
  logic [CELL_W-1:0]   q_idx;
  logic [DIST_W-1:0]   q_dist;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_cmd     = in_tuser[0];
  assign in_kind    = in_tuser[2:1];
  assign in_row     = in_tdata[IN_ROW_W-1:0];
  assign in_col     = in_tdata[IN_ROW_W+IN_COL_W-1:IN_ROW_W];
  assign in_idx     = {ROW_W'(in_row), COL_W'(in_col)};
  assign start_idx  = {start_row_r, start_col_r};

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {(OUT_TDATA_W-DIST_W)'(0), out_dist_r};

  assign cur_row    = cur_idx_r[CELL_W-1:COL_W];
  assign cur_col    = cur_idx_r[COL_W-1:0];
  assign next_dist  = (cur_dist_r == DIST_MAX) ? cur_dist_r : cur_dist_r + DIST_W'(1);
  assign q_idx      = q_rdata[QENT_W-1:DIST_W];
  assign q_dist     = q_rdata[DIST_W-1:0];
  assign q_raddr    = head_r[CELL_W-1:0];

  // shared neighbor unit: one direction per cycle
  always_comb begin
    nb_row = cur_row;
    nb_col = cur_col;
    nb_ok  = 1'b0;
    case (k_r)
      3'd0: begin
        nb_ok  = (cur_row != '0);
        nb_row = cur_row - ROW_W'(1);
      end
      3'd1: begin
        nb_ok  = (SIZE_W'(cur_row) + SIZE_W'(1)) < rows_r;
        nb_row = cur_row + ROW_W'(1);
      end
      3'd2: begin
        nb_ok  = (cur_col != '0);
        nb_col = cur_col - COL_W'(1);
      end
      3'd3: begin
        nb_ok  = (SIZE_W'(cur_col) + SIZE_W'(1)) < cols_r;
        nb_col = cur_col + COL_W'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end
  assign nb_idx = {nb_row, nb_col};

  always_comb begin
    state_nxt      = state_r;
    start_row_nxt  = start_row_r;
    start_col_nxt  = start_col_r;
    start_set_nxt  = start_set_r;
    target_row_nxt = target_row_r;
    target_col_nxt = target_col_r;
    target_set_nxt = target_set_r;
    clr_cnt_nxt    = clr_cnt_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cur_idx_nxt    = cur_idx_r;
    cur_dist_nxt   = cur_dist_r;
    k_nxt          = k_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    res_found_nxt  = res_found_r;
    res_dist_nxt   = res_dist_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_dist_nxt   = out_dist_r;
    wall_we        = 1'b0;
    wall_waddr     = in_idx;
    wall_wdata     = 1'b0;
    vis_we         = 1'b0;
    vis_waddr      = pend_idx_r;
    vis_wdata      = 1'b1;
    q_we           = 1'b0;
    q_waddr        = tail_r[CELL_W-1:0];
    q_wdata        = {pend_idx_r, next_dist};

    case (state_r)
      ST_CLR_ALL: begin
        wall_we     = 1'b1;
        wall_waddr  = clr_cnt_r;
        vis_we      = 1'b1;
        vis_waddr   = clr_cnt_r;
        vis_wdata   = 1'b0;
        clr_cnt_nxt = clr_cnt_r + CELL_W'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && in_cmd == CMD_LOAD) begin
          if (32'(in_row) < MAX_ROWS && 32'(in_col) < MAX_COLS) begin
            wall_we    = 1'b1;
            wall_wdata = (in_kind == KIND_WALL);
            if (in_kind == KIND_START) begin
              start_row_nxt = ROW_W'(in_row);
              start_col_nxt = COL_W'(in_col);
              start_set_nxt = 1'b1;
            end else if (in_kind == KIND_TARGET) begin
              target_row_nxt = ROW_W'(in_row);
              target_col_nxt = COL_W'(in_col);
              target_set_nxt = 1'b1;
            end
          end
        end else if (in_fire) begin
          res_found_nxt = 1'b0;
          res_dist_nxt  = '0;
          clr_cnt_nxt   = '0;
          if (!start_set_r || !target_set_r ||
              SIZE_W'(start_row_r) >= rows_r || SIZE_W'(start_col_r) >= cols_r) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_CLR_VIS;
          end
        end
      end
      ST_CLR_VIS: begin
        vis_we      = 1'b1;
        vis_waddr   = clr_cnt_r;
        vis_wdata   = 1'b0;
        clr_cnt_nxt = clr_cnt_r + CELL_W'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        vis_we    = 1'b1;
        vis_waddr = start_idx;
        q_we      = 1'b1;
        q_waddr   = '0;
        q_wdata   = {start_idx, DIST_W'(0)};
        head_nxt  = '0;
        tail_nxt  = (CELL_W+1)'(1);
        state_nxt = ST_DEQ;
      end
      ST_DEQ: begin
        if (head_r == tail_r) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        cur_idx_nxt  = q_idx;
        cur_dist_nxt = q_dist;
        head_nxt     = head_r + (CELL_W+1)'(1);
        k_nxt        = '0;
        if (q_idx == {target_row_r, target_col_r}) begin
          res_found_nxt = 1'b1;
          res_dist_nxt  = q_dist;
          state_nxt     = ST_FIN;
        end else begin
          state_nxt = ST_NB;
        end
      end
      ST_NB: begin
        if (k_r != 3'd4) begin
          pend_nxt     = nb_ok;
          pend_idx_nxt = nb_idx;
        end
        if (pend_r && !wall_q && !vis_q) begin
          vis_we   = 1'b1;
          q_we     = 1'b1;
          tail_nxt = tail_r + (CELL_W+1)'(1);
        end
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd4) begin
          state_nxt = ST_DEQ;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_dist_nxt  = res_dist_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR_ALL;
      rows_r       <= ROWS_LIMIT;
      cols_r       <= COLS_LIMIT;
      start_row_r  <= '0;
      start_col_r  <= '0;
      start_set_r  <= 1'b0;
      target_row_r <= '0;
      target_col_r <= '0;
      target_set_r <= 1'b0;
      clr_cnt_r    <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      k_r          <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      start_row_r  <= start_row_nxt;
      start_col_r  <= start_col_nxt;
      start_set_r  <= start_set_nxt;
      target_row_r <= target_row_nxt;
      target_col_r <= target_col_nxt;
      target_set_r <= target_set_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      k_r          <= k_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we && cfg_addr == REG_NUM_ROWS) begin
        rows_r <= (cfg_wdata > ROWS_LIMIT) ? ROWS_LIMIT : cfg_wdata;
      end
      if (cfg_we && cfg_addr == REG_NUM_COLS) begin
        cols_r <= (cfg_wdata > COLS_LIMIT) ? COLS_LIMIT : cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_idx_r   <= cur_idx_nxt;
    cur_dist_r  <= cur_dist_nxt;
    pend_idx_r  <= pend_idx_nxt;
    res_found_r <= res_found_nxt;
    res_dist_r  <= res_dist_nxt;
    out_found_r <= out_found_nxt;
    out_dist_r  <= out_dist_nxt;
  end

  // maps and queue
  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_mem[wall_waddr] <= wall_wdata;
    end
    wall_q <= wall_mem[nb_idx];
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_q <= vis_mem[nb_idx];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rdata <= q_mem[q_raddr];
  end

`ifndef NO_ASSERTIONS
  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue head passed tail");

  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= (CELL_W+1)'(CELL_COUNT))
    else $error("queue overflow");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside finish");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_dist_r == '0)
    else $error("nonzero distance on not found");
`endif

endmodule

// ----- verif/tb_grid_bfs_shortest_path.sv -----
// ----------------------------------------------------------------------------
// tb_grid_bfs_shortest_path: self-checking bench for the grid BFS block
// Loads maze cells and issues searches over the stream input. A local BFS
// predicts found/distance for every accepted search, and the monitor checks
// each result in order. Directed cases cover the corner rules first. Random
// phases then vary the grid size, the maze and the handshake timing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_grid_bfs_shortest_path;
  import gbfs_pkg::*;

  localparam longint LIMIT_NS      = 200_000_000;
  localparam int     HOLD_LEN      = 40000;
  localparam int     SETTLE_CYCLES = 16;

  typedef struct packed {
    logic              cmd;
    logic [IN_ROW_W-1:0] row;
    logic [IN_COL_W-1:0] col;
    logic [KIND_W-1:0] kind;
  } maze_item_t;

  typedef struct packed {
    logic              found;
    logic [DIST_W-1:0] steps;
  } route_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [SIZE_W-1:0]      cfg_wdata  = '0;

  grid_bfs_shortest_path DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // maze mirror
  bit                wall_cells [CELL_COUNT];
  bit                seen_cells [CELL_COUNT];
  logic [SIZE_W-1:0] size_rows = 7'd64;
  logic [SIZE_W-1:0] size_cols = 7'd64;
  int unsigned       start_r, start_c, target_r, target_c;
  bit                start_known, target_known;

  maze_item_t item_feed [$];
  route_t     route_expect [$];
  maze_item_t offer_item;

  bit  idle_on = 1'b0;
  int  tx_wait, rx_wait;
  bit  rx_hold;
  int  hold_cycles, holds_done;
  int  holds_asked = 0;
  int  items_pushed = 0;
  int  runs_pushed = 0;
  int  items_taken = 0;
  int  loads_taken = 0;
  int  runs_taken = 0;
  int  reach_count = 0;
  int  grid_writes = 0;
  int  fail_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic route_t trace_route();
    route_t      res;
    int unsigned rows, cols, idx, nidx, r, c, d, nr, nc, k;
    int unsigned frontier [$];
    int unsigned depth [$];
    bit          step_ok;
    res  = '0;
    rows = (size_rows > ROWS_LIMIT) ? MAX_ROWS : size_rows;
    cols = (size_cols > COLS_LIMIT) ? MAX_COLS : size_cols;
    if (!start_known || !target_known || start_r >= rows || start_c >= cols) return res;
    foreach (seen_cells[i]) seen_cells[i] = 1'b0;
    idx = start_r * MAX_COLS + start_c;
    seen_cells[idx] = 1'b1;
    frontier.push_back(idx);
    depth.push_back(0);
    while (frontier.size() != 0) begin
      idx = frontier.pop_front();
      d   = depth.pop_front();
      r   = idx / MAX_COLS;
      c   = idx % MAX_COLS;
      if (r == target_r && c == target_c) begin
        res.found = 1'b1;
        res.steps = (d > DIST_MAX) ? DIST_MAX : DIST_W'(d);
        return res;
      end
      for (k = 0; k < 4; k++) begin
        step_ok = 1'b1;
        nr = r;
        nc = c;
        case (k)
          0: if (r == 0) step_ok = 1'b0; else nr = r - 1;
          1: if (r + 1 >= rows) step_ok = 1'b0; else nr = r + 1;
          2: if (c == 0) step_ok = 1'b0; else nc = c - 1;
          default: if (c + 1 >= cols) step_ok = 1'b0; else nc = c + 1;
        endcase
        if (step_ok) begin
          nidx = nr * MAX_COLS + nc;
          if (!wall_cells[nidx] && !seen_cells[nidx]) begin
            seen_cells[nidx] = 1'b1;
            frontier.push_back(nidx);
            depth.push_back(d + 1);
          end
        end
      end
    end
    return res;
  endfunction

  function automatic void predict_item(maze_item_t it);
    route_t      res;
    int unsigned idx;
    if (it.cmd == CMD_RUN) begin
      res = trace_route();
      route_expect.push_back(res);
      runs_taken++;
      if (res.found) reach_count++;
    end else begin
      idx = int'(it.row) * MAX_COLS + int'(it.col);
      wall_cells[idx] = (it.kind == KIND_WALL);
      if (it.kind == KIND_START) begin
        start_r     = it.row;
        start_c     = it.col;
        start_known = 1'b1;
      end else if (it.kind == KIND_TARGET) begin
        target_r     = it.row;
        target_c     = it.col;
        target_known = 1'b1;
      end
      loads_taken++;
    end
    items_taken++;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      tx_wait   <= 0;
    end else begin
      if (in_tvalid && in_tready) predict_item(offer_item);
      if (!in_tvalid || in_tready) begin
        if (tx_wait != 0) begin
          tx_wait   <= tx_wait - 1;
          in_tvalid <= 1'b0;
        end else if (item_feed.size() != 0) begin
          offer_item = item_feed.pop_front();
          in_tdata  <= {4'b0, offer_item.col, offer_item.row};
          in_tuser  <= {offer_item.kind, offer_item.cmd};
          in_tvalid <= 1'b1;
          tx_wait   <= idle_on ? $urandom_range(0, 15) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted over cycles with a result waiting
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold     <= 1'b0;
      hold_cycles <= 0;
      holds_done  <= 0;
    end else if (rx_hold) begin
      if (out_tvalid) begin
        if (hold_cycles == HOLD_LEN - 1) begin
          rx_hold    <= 1'b0;
          holds_done <= holds_done + 1;
        end
        hold_cycles <= hold_cycles + 1;
      end
    end else if (holds_done < holds_asked) begin
      rx_hold     <= 1'b1;
      hold_cycles <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    route_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (route_expect.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: found=%0b distance=%0d",
                     out_tuser, out_tdata[DIST_W-1:0]);
        end else begin
          want = route_expect.pop_front();
          if (out_tuser !== want.found || out_tdata[DIST_W-1:0] !== want.steps) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected found=%0b distance=%0d, got found=%0b distance=%0d",
                       want.found, want.steps, out_tuser, out_tdata[DIST_W-1:0]);
          end
        end
        rx_wait    <= idle_on ? $urandom_range(0, 15) : 0;
        out_tready <= 1'b0;
      end else if (out_tvalid && !rx_hold) begin
        if (rx_wait == 0) out_tready <= 1'b1;
        else rx_wait <= rx_wait - 1;
      end else begin
        out_tready <= 1'b0;
      end
    end
  end

  task automatic set_grid(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_NUM_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_addr  <= REG_NUM_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_rows = rows;
    size_cols = cols;
    grid_writes++;
    @(negedge clk);
  endtask

  task automatic queue_load(input int r, input int c, input logic [KIND_W-1:0] kind);
    maze_item_t it;
    it.cmd  = CMD_LOAD;
    it.row  = IN_ROW_W'(r);
    it.col  = IN_COL_W'(c);
    it.kind = kind;
    item_feed.push_back(it);
    items_pushed++;
  endtask

  task automatic queue_run();
    maze_item_t it;
    it.cmd  = CMD_RUN;
    it.row  = IN_ROW_W'($urandom_range(0, 63));
    it.col  = IN_COL_W'($urandom_range(0, 63));
    it.kind = KIND_W'($urandom_range(0, 3));
    item_feed.push_back(it);
    items_pushed++;
    runs_pushed++;
  endtask

  // sender pause: wait for every search result, then let the block go idle
  task automatic settle();
    while (items_taken != items_pushed || route_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int                base_items, base_runs, phase_no, big_left;
    int                j, n, n_runs, span_r, span_c, pick;
    bit                tidy;
    logic [SIZE_W-1:0] rows, cols;
    logic [KIND_W-1:0] kind;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corner cases, reset grid size 64 x 64
    idle_on = 1'b0;
    queue_run();                          // nothing loaded yet
    queue_load(0, 0, KIND_START);
    queue_run();                          // target never loaded
    queue_load(63, 63, KIND_TARGET);
    queue_run();                          // open full grid, far corner
    queue_load(0, 0, KIND_TARGET);
    queue_run();                          // start equals target
    queue_load(0, 0, KIND_WALL);
    queue_run();                          // start and target on a wall
    queue_load(0, 5, KIND_TARGET);
    queue_run();                          // search leaves from a walled start
    queue_load(0, 5, KIND_WALL);
    queue_run();                          // target on a wall
    queue_load(0, 5, KIND_OPEN);
    settle();
    set_grid(7'd0, 7'd127);               // no rows in use
    queue_run();
    settle();
    set_grid(7'd127, 7'd1);               // target column outside the grid
    queue_run();
    settle();
    set_grid(7'd1, 7'd64);
    queue_run();
    settle();

    // random phases
    base_items = items_pushed;
    base_runs  = runs_pushed;
    big_left   = 3;
    phase_no   = 0;
    while ((items_pushed - base_items) < 85 || (runs_pushed - base_runs) < 10) begin
      if (big_left > 0 && $urandom_range(0, 7) == 0) begin
        big_left--;
        rows = SIZE_W'($urandom_range(64, 127));
        cols = SIZE_W'($urandom_range(64, 127));
      end else begin
        rows = ($urandom_range(0, 15) == 0) ? 7'd0 : SIZE_W'($urandom_range(1, 10));
        cols = ($urandom_range(0, 15) == 0) ? 7'd0 : SIZE_W'($urandom_range(1, 10));
      end
      set_grid(rows, cols);
      span_r  = (rows == 0) ? 1 : ((rows > 64) ? 64 : rows);
      span_c  = (cols == 0) ? 1 : ((cols > 64) ? 64 : cols);
      idle_on = ($urandom_range(0, 3) != 0);
      tidy    = ($urandom_range(0, 9) < 7);
      n_runs  = $urandom_range(1, 2);
      if (phase_no == 2) begin
        holds_asked++;
        n_runs = 3;
      end
      for (j = 0; j < n_runs; j++) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if (tidy) begin
            pick = $urandom_range(0, 9);
            kind = (pick < 6) ? KIND_WALL : (pick < 9) ? KIND_OPEN :
                   (pick == 9 && $urandom_range(0, 1)) ? KIND_START : KIND_TARGET;
            queue_load($urandom_range(0, span_r - 1), $urandom_range(0, span_c - 1), kind);
          end else begin
            queue_load($urandom_range(0, 63), $urandom_range(0, 63),
                       KIND_W'($urandom_range(0, 3)));
          end
        end
        if (tidy && j == 0) begin
          queue_load($urandom_range(0, span_r - 1), $urandom_range(0, span_c - 1), KIND_START);
          queue_load($urandom_range(0, span_r - 1), $urandom_range(0, span_c - 1), KIND_TARGET);
        end
        queue_run();
      end
      settle();
      phase_no++;
    end

    settle();
    $display("run covered %0d cell loads and %0d searches, %0d of them reaching the target,",
             loads_taken, runs_taken, reach_count);
    $display("over %0d grid size settings with %0d long receiver hold-offs",
             grid_writes, holds_done);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
